/* rtl/tws_pkg.sv */
`default_nettype none

package tws_pkg;

    // Command codes as they arrive on the request side.
    localparam logic [3:0] FN_NONE  = 4'd0;
    localparam logic [3:0] FN_START = 4'd1;
    localparam logic [3:0] FN_STOP  = 4'd2;
    localparam logic [3:0] FN_ACK   = 4'd3;
    localparam logic [3:0] FN_NACK  = 4'd4;
    localparam logic [3:0] FN_CHECK = 4'd5;
    localparam logic [3:0] FN_WRITE = 4'd6;
    localparam logic [3:0] FN_READ  = 4'd7;
    localparam logic [3:0] FN_BURST = 4'd8;

    localparam int TICK_W  = 15;
    localparam int BURST_W = 14;

    // Sequencer state: the command in progress, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_START = 9'b000000010,
        ST_STOP  = 9'b000000100,
        ST_ACK   = 9'b000001000,
        ST_NACK  = 9'b000010000,
        ST_CHECK = 9'b000100000,
        ST_WRITE = 9'b001000000,
        ST_READ  = 9'b010000000,
        ST_BURST = 9'b100000000
    } t_state;

    // Levels of the two lines; rel means the data line is released.
    typedef struct packed {
        logic rel;
        logic sda;
        logic scl;
    } t_line;

    // One result per tick, handed from the sequencer core to the output stage.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       rel;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } t_result;

endpackage

`default_nettype wire

/* rtl/tws_core.sv */
`default_nettype none

module tws_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [3:0]                  i_func,
    input  wire logic [7:0]                  i_tx_byte,
    input  wire logic [tws_pkg::BURST_W-1:0] i_burst_periods,
    input  wire logic                        i_sda_in,
    output tws_pkg::t_result                 o_res
);
    import tws_pkg::*;

    t_state               r_state;
    logic [TICK_W-1:0]    r_tick;
    logic [7:0]           r_sr;
    logic [BURST_W-1:0]   r_bl;
    t_line                r_line;
    logic                 r_ack;

    t_state               dec;
    t_state               st_eff;
    logic                 launch;
    logic [TICK_W-1:0]    t;
    logic [7:0]           sr;
    logic [BURST_W-1:0]   bl;
    logic [BURST_W-1:0]   bl_dec;
    logic                 busy;
    logic                 done;
    logic                 wr_bit;
    logic [7:0]           rx;
    t_line                cur;
    t_line                fin;
    logic [7:0]           n_sr;
    logic [BURST_W-1:0]   n_bl;
    logic                 n_ack;

    // Decode the requested command; unknown codes leave the block idle.
    always_comb begin
        unique case (i_func)
            FN_START: dec = ST_START;
            FN_STOP:  dec = ST_STOP;
            FN_ACK:   dec = ST_ACK;
            FN_NACK:  dec = ST_NACK;
            FN_CHECK: dec = ST_CHECK;
            FN_WRITE: dec = ST_WRITE;
            FN_READ:  dec = ST_READ;
            FN_BURST: dec = ST_BURST;
            default:  dec = ST_IDLE;
        endcase
    end

    // A command launched on this tick starts from a fresh count and operands.
    assign launch = (r_state == ST_IDLE);
    assign st_eff = launch ? dec : r_state;
    assign t      = launch ? '0 : r_tick;
    assign busy   = (st_eff != ST_IDLE);
    assign bl     = (launch && dec == ST_BURST) ? i_burst_periods : r_bl;
    assign bl_dec = bl - BURST_W'(1);
    assign wr_bit = sr[~t[3:1]];

    always_comb begin
        if (launch && dec == ST_WRITE) begin
            sr = i_tx_byte;
        end else if (launch && dec == ST_READ) begin
            sr = '0;
        end else begin
            sr = r_sr;
        end
    end

    // Line levels, completion and operand updates for the current tick.
    always_comb begin
        cur   = r_line;
        fin   = r_line;
        done  = 1'b0;
        rx    = '0;
        n_sr  = sr;
        n_bl  = bl;
        n_ack = r_ack;
        unique case (st_eff) inside
            ST_IDLE: begin
                cur = r_line;
            end
            ST_START: begin
                cur  = '{rel: 1'b0, sda: (t < TICK_W'(2)), scl: (t != '0)};
                done = (t >= TICK_W'(2));
                fin  = '{rel: 1'b0, sda: 1'b0, scl: 1'b0};
            end
            ST_STOP: begin
                cur  = '{rel: 1'b0, sda: (t >= TICK_W'(2)), scl: (t != '0)};
                done = (t >= TICK_W'(2));
                fin  = '{rel: 1'b0, sda: 1'b1, scl: 1'b1};
            end
            ST_ACK, ST_NACK: begin
                cur  = '{rel: 1'b0, sda: (st_eff == ST_NACK), scl: (t != '0)};
                done = (t != '0);
                fin  = '{rel: 1'b0, sda: (st_eff == ST_NACK), scl: 1'b0};
            end
            ST_CHECK: begin
                cur = '{rel: 1'b1, sda: 1'b0, scl: (t != '0)};
                if (t != '0) begin
                    n_ack = ~i_sda_in;
                    done  = 1'b1;
                end
                fin = '{rel: 1'b1, sda: 1'b0, scl: 1'b0};
            end
            ST_WRITE: begin
                cur  = '{rel: 1'b0, sda: wr_bit, scl: t[0]};
                done = (t >= TICK_W'(15));
                fin  = '{rel: 1'b0, sda: wr_bit, scl: 1'b0};
            end
            ST_READ: begin
                cur = '{rel: 1'b1, sda: 1'b0, scl: t[0]};
                // Sample at the end of each low tick, most significant bit first.
                if (!t[0]) begin
                    n_sr = {sr[6:0], i_sda_in};
                end
                if (t >= TICK_W'(15)) begin
                    done = 1'b1;
                    rx   = n_sr;
                end
                fin = '{rel: 1'b1, sda: 1'b0, scl: 1'b0};
            end
            ST_BURST: begin
                if (bl == '0) begin
                    cur  = '{rel: r_line.rel, sda: r_line.sda, scl: 1'b0};
                    done = 1'b1;
                end else begin
                    cur = '{rel: r_line.rel, sda: r_line.sda, scl: t[0]};
                    if (t[0]) begin
                        n_bl = bl_dec;
                        done = (bl_dec == '0);
                    end
                end
                fin = '{rel: r_line.rel, sda: r_line.sda, scl: 1'b0};
            end
            default: begin
                cur = r_line;
            end
        endcase
    end

    // State advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tick  <= '0;
            r_sr    <= '0;
            r_bl    <= '0;
            r_line  <= '0;
            r_ack   <= 1'b0;
        end else if (i_step && busy) begin
            r_sr  <= n_sr;
            r_bl  <= n_bl;
            r_ack <= n_ack;
            if (done) begin
                r_state <= ST_IDLE;
                r_tick  <= '0;
                r_line  <= fin;
            end else begin
                r_state <= st_eff;
                r_tick  <= t + TICK_W'(1);
                r_line  <= cur;
            end
        end
    end

    assign o_res = '{
        scl:  cur.scl,
        sda:  cur.sda & ~cur.rel,
        rel:  cur.rel,
        busy: busy,
        done: done,
        rx:   rx,
        ack:  n_ack
    };

endmodule

`default_nettype wire

/* rtl/two_wire_master_bit_sequencer.sv */
`default_nettype none

// Channel   Direction  tdata fields (low bit up)                     tuser      tlast
// s_axis    in         tx_byte[7:0] burst_periods[21:8] sda_in[22]   func[3:0]  -
// m_axis    out        scl[0] sda[1] released[2] busy[3]             -          done
//                      rx_byte[11:4] ack_ok[12]
//
// Each request is one delay tick and yields exactly one result, in the cycle after
// acceptance, through a single output register.
// One request per cycle unless results stall; the output register is the only stage.
// Reset puts the sequencer idle with clock low and data driven low, ack_ok 0.
// When the result side stalls, tready drops only while the output register is full.
module two_wire_master_bit_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // tx_byte, burst_periods, sda_in, zero pad
    input  wire logic [3:0]  s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // scl, sda, released, busy, rx_byte, ack_ok
    output logic             m_axis_tlast
);
    import tws_pkg::*;

    logic    step;
    t_result res;
    t_result r_res;
    logic    r_valid;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    tws_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_func          (s_axis_tuser),
        .i_tx_byte       (s_axis_tdata[7:0]),
        .i_burst_periods (s_axis_tdata[21:8]),
        .i_sda_in        (s_axis_tdata[22]),
        .o_res           (res)
    );

    // Output register for the result of each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tlast  = r_res.done;
    assign m_axis_tdata  = {3'b000, r_res.ack, r_res.rx, r_res.busy,
                            r_res.rel, r_res.sda, r_res.scl};

    // A finished command is always a busy tick.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3])
        else $error("done without busy");

    // A released data line is never reported as driven high.
    a_rel_sda: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[1])
        else $error("data driven while released");

    // The received byte is shown only on the final tick of a command.
    a_rx_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[11:4] == 8'd0)
        else $error("rx byte outside final tick");

    // An idle result never carries a completion.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[3] |-> !m_axis_tlast)
        else $error("done while idle");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tws_pkg::*;

    // Codes above the burst command are not commands and must be ignored.
    localparam logic [3:0] FN_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] FN_LAST_UNUSED  = 4'd15;
    localparam int         RANDOM_TICKS    = 1100;
    localparam int         HOLD_AT_REQ     = 300;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         DRAIN_CYCLES    = 10;

    // How the data line is driven back to the master during a command.
    typedef enum int {
        SDA_LOW,
        SDA_HIGH,
        SDA_RAND
    } t_sda_fill;

    typedef struct {
        logic [3:0]  func;
        logic [7:0]  tx;
        logic [13:0] periods;
        logic        sda_in;
    } t_tick_req;

    typedef struct {
        logic       scl;
        logic       sda;
        logic       rel;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } t_line_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // tx_byte, burst_periods, sda_in, zero pad
    logic [3:0]  s_axis_tuser = '0;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // scl, sda, released, busy, rx_byte, ack_ok
    logic        m_axis_tlast;

    t_tick_req    pending_ticks[$];
    t_line_result expected_lines[$];
    int           fail_cnt = 0;
    int           req_count = 0;
    logic         req_taken = 1'b0;

    // Mirror of the sequencer state.
    logic [3:0]  cur_cmd = FN_NONE;
    logic [14:0] tick_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [13:0] burst_cnt = '0;
    t_line       lines = '0;
    logic        ack_seen = 1'b0;

    two_wire_master_bit_sequencer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_line line_of(logic scl, logic sda, logic rel);
        t_line l;
        l.scl = scl;
        l.sda = sda;
        l.rel = rel;
        return l;
    endfunction

    // Number of ticks a command occupies once accepted.
    function automatic int cmd_ticks(logic [3:0] fn, logic [13:0] per);
        case (fn)
            FN_START, FN_STOP:           return 3;
            FN_ACK, FN_NACK, FN_CHECK:   return 2;
            FN_WRITE, FN_READ:           return 16;
            FN_BURST:                    return (per == 0) ? 1 : 2 * int'(per);
            default:                     return 1;
        endcase
    endfunction

    // Random gap length; every fourth stretch of requests runs without gaps.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if ((req_count / 500) % 4 == 3) return 0;
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Advances the line sequencer by one tick and returns the levels it gives.
    task automatic sequence_tick(input t_tick_req r, output t_line_result e);
        t_line       cur;
        t_line       fin;
        logic [14:0] t;
        logic        fin_now;
        logic [7:0]  rx;
        logic        bitv;
        logic        dlev;
        fin_now = 1'b0;
        rx = '0;
        e.busy = 1'b0;
        if (cur_cmd == FN_NONE && r.func >= FN_START && r.func <= FN_BURST) begin
            cur_cmd = r.func;
            tick_cnt = '0;
            if (r.func == FN_WRITE) shreg = r.tx;
            if (r.func == FN_READ) shreg = '0;
            if (r.func == FN_BURST) burst_cnt = r.periods;
        end
        cur = lines;
        fin = lines;
        t = tick_cnt;
        if (cur_cmd != FN_NONE) begin
            e.busy = 1'b1;
            case (cur_cmd)
                FN_START: begin
                    cur = line_of(t != 0, t < 2, 1'b0);
                    fin_now = (t >= 2);
                    fin = line_of(1'b0, 1'b0, 1'b0);
                end
                FN_STOP: begin
                    cur = line_of(t != 0, t >= 2, 1'b0);
                    fin_now = (t >= 2);
                    fin = line_of(1'b1, 1'b1, 1'b0);
                end
                FN_ACK, FN_NACK: begin
                    dlev = (cur_cmd == FN_NACK);
                    cur = line_of(t != 0, dlev, 1'b0);
                    fin_now = (t >= 1);
                    fin = line_of(1'b0, dlev, 1'b0);
                end
                FN_CHECK: begin
                    cur = line_of(t != 0, 1'b0, 1'b1);
                    // The acknowledge is sampled on the high tick.
                    if (t >= 1) begin
                        ack_seen = !r.sda_in;
                        fin_now = 1'b1;
                    end
                    fin = line_of(1'b0, 1'b0, 1'b1);
                end
                FN_WRITE: begin
                    bitv = shreg[3'd7 - t[3:1]];
                    cur = line_of(t[0], bitv, 1'b0);
                    fin_now = (t >= 15);
                    fin = line_of(1'b0, bitv, 1'b0);
                end
                FN_READ: begin
                    cur = line_of(t[0], 1'b0, 1'b1);
                    // Data is shifted in at the end of each low tick.
                    if (!t[0]) shreg = {shreg[6:0], r.sda_in};
                    if (t >= 15) begin
                        fin_now = 1'b1;
                        rx = shreg;
                    end
                    fin = line_of(1'b0, 1'b0, 1'b1);
                end
                default: begin
                    // Clock burst: data keeps its level, clock toggles per tick.
                    cur = lines;
                    if (burst_cnt == 0) begin
                        cur.scl = 1'b0;
                        fin_now = 1'b1;
                    end else begin
                        cur.scl = t[0];
                        if (t[0]) begin
                            burst_cnt = burst_cnt - 1'b1;
                            if (burst_cnt == 0) fin_now = 1'b1;
                        end
                    end
                    fin = lines;
                    fin.scl = 1'b0;
                end
            endcase
            tick_cnt = tick_cnt + 1'b1;
            if (fin_now) begin
                lines = fin;
                cur_cmd = FN_NONE;
                tick_cnt = '0;
            end else begin
                lines = cur;
            end
        end
        e.scl = cur.scl;
        e.sda = !cur.rel && cur.sda;
        e.rel = cur.rel;
        e.done = fin_now;
        e.rx = rx;
        e.ack = ack_seen;
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Queues a command tick followed by the ticks it keeps the sequencer busy.
    // Fields other than sda_in are random there, since the block ignores them.
    task automatic push_cmd(input logic [3:0] fn, input logic [7:0] tx,
                            input logic [13:0] per, input t_sda_fill fill);
        t_tick_req r;
        int        len;
        len = cmd_ticks(fn, per);
        for (int k = 0; k < len; k++) begin
            if (k == 0) begin
                r.func = fn;
                r.tx = tx;
                r.periods = per;
            end else begin
                r.func = 4'($urandom_range(0, 15));
                r.tx = 8'($urandom_range(0, 255));
                r.periods = 14'($urandom_range(0, 16383));
            end
            case (fill)
                SDA_LOW:  r.sda_in = 1'b0;
                SDA_HIGH: r.sda_in = 1'b1;
                default:  r.sda_in = 1'($urandom_range(0, 1));
            endcase
            pending_ticks.push_back(r);
        end
    endtask

    task automatic push_rand(input logic [3:0] fn);
        push_cmd(fn, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)), SDA_RAND);
    endtask

    // A typical bus transaction: start, writes with acknowledge checks,
    // reads acknowledged by the master, the last one not acknowledged, an optional clock burst, stop.
    task automatic queue_frame();
        int n;
        n = $urandom_range(1, 3);
        push_rand(FN_START);
        repeat (n) begin
            push_rand(FN_WRITE);
            push_rand(FN_CHECK);
        end
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            push_rand(FN_READ);
            push_rand((i == n - 1) ? FN_NACK : FN_ACK);
        end
        if ($urandom_range(0, 3) == 0) begin
            push_cmd(FN_BURST, 8'($urandom_range(0, 255)), 14'($urandom_range(0, 5)),
                     SDA_RAND);
        end
        push_rand(FN_STOP);
    endtask

    task automatic fill_requests();
        int          base;
        int          r;
        logic [13:0] per;
        // Directed part: every command, line extremes, ignored codes, burst sizes.
        push_cmd(FN_NONE, 8'h00, 14'h0000, SDA_LOW);
        push_cmd(FN_START, 8'h00, 14'h0000, SDA_LOW);
        push_cmd(FN_WRITE, 8'hFF, 14'h3FFF, SDA_HIGH);
        push_cmd(FN_CHECK, 8'h00, 14'h0000, SDA_LOW);
        push_cmd(FN_WRITE, 8'h00, 14'h0000, SDA_LOW);
        push_cmd(FN_CHECK, 8'hFF, 14'h3FFF, SDA_HIGH);
        push_cmd(FN_WRITE, 8'hA5, 14'h1555, SDA_RAND);
        push_cmd(FN_READ, 8'h00, 14'h0000, SDA_HIGH);
        push_cmd(FN_ACK, 8'h00, 14'h0000, SDA_RAND);
        push_cmd(FN_READ, 8'hFF, 14'h3FFF, SDA_LOW);
        push_cmd(FN_NACK, 8'h00, 14'h0000, SDA_RAND);
        push_cmd(FN_READ, 8'h5A, 14'h2AAA, SDA_RAND);
        push_cmd(FN_ACK, 8'h00, 14'h0000, SDA_RAND);
        push_cmd(FN_STOP, 8'h00, 14'h0000, SDA_RAND);
        push_cmd(FN_NONE, 8'hFF, 14'h3FFF, SDA_HIGH);
        push_cmd(FN_FIRST_UNUSED, 8'hFF, 14'h3FFF, SDA_HIGH);
        push_cmd(FN_LAST_UNUSED, 8'h00, 14'h0005, SDA_LOW);
        push_cmd(FN_BURST, 8'h00, 14'd0, SDA_RAND);
        push_cmd(FN_BURST, 8'h00, 14'd1, SDA_RAND);
        push_cmd(FN_NACK, 8'h00, 14'h0000, SDA_RAND);
        push_cmd(FN_BURST, 8'h00, 14'd37, SDA_RAND);
        push_cmd(FN_CHECK, 8'h00, 14'h0000, SDA_RAND);
        push_cmd(FN_BURST, 8'hFF, 14'd50, SDA_RAND);
        push_cmd(FN_STOP, 8'h00, 14'h0000, SDA_RAND);

        // Random part: mostly well-formed transactions, some loose commands and noise.
        base = pending_ticks.size();
        while (pending_ticks.size() - base < RANDOM_TICKS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                queue_frame();
            end else if (r < 85) begin
                per = ($urandom_range(0, 19) == 0) ? 14'($urandom_range(6, 60))
                                                   : 14'($urandom_range(0, 5));
                push_cmd(4'($urandom_range(FN_START, FN_BURST)),
                         8'($urandom_range(0, 255)), per, SDA_RAND);
            end else begin
                push_rand(($urandom_range(0, 1) == 0) ? FN_NONE
                          : 4'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED)));
            end
        end
    endtask

    // Request driver: a new request goes out once the previous one was taken.
    int gap_left = 0;
    always @(negedge i_clk) begin
        t_tick_req r;
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left = gap_left - 1;
            end else if (pending_ticks.size() > 0) begin
                r = pending_ticks.pop_front();
                s_axis_tuser <= r.func;
                s_axis_tdata <= {1'b0, r.sda_in, r.periods, r.tx};
                s_axis_tvalid <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side readiness: random stalls plus one long hold-off while the
    // request side keeps offering, so the block backs up into its input.
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_done && req_count >= HOLD_AT_REQ) begin
            m_axis_tready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Monitor: predict on each accepted request, check each accepted result.
    always @(posedge i_clk) begin
        t_tick_req    r;
        t_line_result e;
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                r.func = s_axis_tuser;
                r.tx = s_axis_tdata[7:0];
                r.periods = s_axis_tdata[21:8];
                r.sda_in = s_axis_tdata[22];
                sequence_tick(r, e);
                expected_lines.push_back(e);
                req_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_lines.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end else begin
                    e = expected_lines.pop_front();
                    compare_field("scl_level", e.scl, m_axis_tdata[0]);
                    compare_field("sda_level", e.sda, m_axis_tdata[1]);
                    compare_field("sda_released", e.rel, m_axis_tdata[2]);
                    compare_field("busy_res", e.busy, m_axis_tdata[3]);
                    compare_field("done_res", e.done, m_axis_tlast);
                    compare_field("rx_byte", e.rx, m_axis_tdata[11:4]);
                    compare_field("ack_ok", e.ack, m_axis_tdata[12]);
                end
            end
        end
    end

    initial begin
        fill_requests();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_ticks.size() != 0 || s_axis_tvalid || expected_lines.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_lines.size() != 0) begin
            $error("%0d results never arrived", expected_lines.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* two_wire_master_bit_sequencer.f */
rtl/tws_pkg.sv
rtl/tws_core.sv
rtl/two_wire_master_bit_sequencer.sv
sim/tb_top.sv
